@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SAL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Expression that must never be true outside reset.
`define SAL_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/sal_pkg.sv @@
`default_nettype none

package sal_pkg;

  localparam int SETS     = 64;
  localparam int WAYS     = 4;
  localparam int TAG_BITS = 32;

  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_BITS = WAY_BITS;

  // Stream payload widths (fields packed low first, padded to bytes).
  localparam int IN_W  = 48;
  localparam int OUT_W = 40;

  typedef enum logic [2:0] {
    OP_LOOKUP    = 3'd0,
    OP_SET_STATE = 3'd1,
    OP_TOUCH     = 3'd2,
    OP_CHECK     = 3'd3,
    OP_INSERT    = 3'd4
  } op_t;

  localparam logic [2:0] ST_INVALID  = 3'd0;
  localparam logic [2:0] ST_MODIFIED = 3'd1;
  localparam logic [2:0] ST_OWNED    = 3'd2;
  localparam logic [2:0] ST_SHARED   = 3'd4;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [2:0]          state;
    logic [AGE_BITS-1:0] age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic        hit;
    logic [2:0]  line_state;
    logic [31:0] victim_tag;
    logic        writeback_needed;
  } res_t;

  function automatic row_t reset_row();
    row_t r;
    for (int j = 0; j < WAYS; j++) begin
      r[j].tag   = TAG_BITS'(j);
      r[j].state = ST_INVALID;
      r[j].age   = AGE_BITS'(WAYS - 1 - j);
    end
    return r;
  endfunction

  // Set index wraps modulo SETS; constant table over the 6-bit input.
  function automatic logic [SET_BITS-1:0] set_of(logic [5:0] idx);
    logic [SET_BITS-1:0] r;
    r = '0;
    for (int v = 0; v < 64; v++) begin
      if (idx == 6'(v)) r = SET_BITS'(v % SETS);
    end
    return r;
  endfunction

  function automatic logic [TAG_BITS-1:0] tag_in(logic [31:0] t);
    logic [TAG_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < TAG_BITS && i < 32; i++) r[i] = t[i];
    return r;
  endfunction

  function automatic logic [31:0] tag_out(logic [TAG_BITS-1:0] t);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < TAG_BITS && i < 32; i++) r[i] = t[i];
    return r;
  endfunction

  // Way w becomes most recent; every younger way ages by one.
  function automatic row_t promote(row_t r, logic [WAY_BITS-1:0] w);
    row_t                o;
    logic [AGE_BITS-1:0] a;
    o = r;
    a = r[w].age;
    for (int k = 0; k < WAYS; k++) begin
      if (r[k].age < a) o[k].age = r[k].age + AGE_BITS'(1);
    end
    o[w].age = '0;
    return o;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sal_ram.sv @@
`default_nettype none

module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/sal_row_update.sv @@
`default_nettype none

module sal_row_update (
  input  wire sal_pkg::row_t                  row,
  input  wire sal_pkg::op_t                   op,
  input  wire logic [sal_pkg::TAG_BITS-1:0]   tag,
  input  wire logic [2:0]                     new_state,
  output sal_pkg::row_t                       row_next,
  output sal_pkg::res_t                       res
);
  import sal_pkg::*;

  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] lru_way;
  logic [2:0]          ns;
  logic [2:0]          vst;
  row_t                r;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      // ages are a permutation, so exactly one way is the oldest
      if (row[w].age == AGE_BITS'(WAYS - 1)) lru_way = WAY_BITS'(w);
    end

    ns  = (new_state > ST_SHARED) ? ST_INVALID : new_state;
    vst = row[lru_way].state;

    res.hit              = hit;
    res.line_state       = hit ? row[hit_way].state : ST_INVALID;
    res.victim_tag       = tag_out(row[lru_way].tag);
    res.writeback_needed = (vst == ST_MODIFIED) || (vst == ST_OWNED);

    r = row;
    case (op)
      OP_SET_STATE: begin
        if (hit) r[hit_way].state = ns;
      end
      OP_TOUCH: begin
        if (hit) r = promote(row, hit_way);
      end
      OP_INSERT: begin
        if (hit) begin
          r = promote(row, hit_way);
          r[hit_way].state = ns;
        end else begin
          r = promote(row, lru_way);
          r[lru_way].tag   = tag;
          r[lru_way].state = ns;
        end
      end
      default: r = row;
    endcase
    row_next = r;
  end

endmodule

`default_nettype wire

@@ hdl/set_assoc_lru_tag_store.sv @@
// A request is registered as its set row is read from RAM; its result is then
// registered onto m_axis. Throughput: one request per cycle unless m_axis stalls;
// its row is updated and written back, forwarded if the next request hits that set.
// Reset: synchronous; per-set valid flags clear so every set reads as its reset
// row (way j holds tag j, invalid, way 0 least recent) until first written.
`default_nettype none

module set_assoc_lru_tag_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // operation[2:0], set_index[8:3], tag[40:9], new_state[43:41], zero pad
  input  wire logic [sal_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // hit[0], line_state[3:1], victim_tag[35:4], writeback_needed[36], zero pad
  output logic      [sal_pkg::OUT_W-1:0] m_axis_tdata
);
  import sal_pkg::*;

  logic                advance;
  logic                accept;
  logic [SET_BITS-1:0] in_set;

  logic                b_valid;
  op_t                 b_op;
  logic [SET_BITS-1:0] b_set;
  logic [TAG_BITS-1:0] b_tag;
  logic [2:0]          b_ns;

  logic [SETS-1:0]     row_written;
  logic                row_valid;
  logic                fwd;
  row_t                fwd_row;
  logic [ROW_W-1:0]    ram_rdata;
  row_t                cur_row;
  row_t                new_row;
  res_t                res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;
  assign in_set        = set_of(s_axis_tdata[8:3]);

  sal_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (advance && b_valid),
    .waddr (b_set),
    .wdata (new_row),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd) cur_row = fwd_row;
    else if (row_valid) cur_row = row_t'(ram_rdata);
    else cur_row = reset_row();
  end

  sal_row_update u_upd (
    .row       (cur_row),
    .op        (b_op),
    .tag       (b_tag),
    .new_state (b_ns),
    .row_next  (new_row),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      row_written   <= '0;
      fwd           <= 1'b0;
    end else if (advance) begin
      b_valid       <= accept;
      m_axis_tvalid <= b_valid;
      if (b_valid) row_written[b_set] <= 1'b1;
      if (accept) begin
        row_valid <= row_written[in_set];
        // write of the older request lands on the same edge as this read
        fwd       <= b_valid && (b_set == in_set);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_op    <= op_t'(s_axis_tdata[2:0]);
      b_set   <= in_set;
      b_tag   <= tag_in(s_axis_tdata[40:9]);
      b_ns    <= s_axis_tdata[43:41];
      fwd_row <= new_row;
    end
    if (advance && b_valid) begin
      m_axis_tdata <= {3'b000, res.writeback_needed, res.victim_tag,
                       res.line_state, res.hit};
    end
  end

endmodule

`default_nettype wire

@@ hdl/sal_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module sal_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [sal_pkg::IN_W-1:0]  s_axis_tdata,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [sal_pkg::OUT_W-1:0] m_axis_tdata
);
  import sal_pkg::*;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

  `SAL_ASSERT(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  `SAL_ASSERT(a_miss_invalid, clk, rst,
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[3:1] == ST_INVALID)

  `SAL_NEVER(a_state_range, clk, rst,
    m_axis_tvalid && (m_axis_tdata[3:1] > ST_SHARED))

  `SAL_ASSERT(a_result_follows, clk, rst,
    in_beat ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)

endmodule

bind set_assoc_lru_tag_store sal_checker u_sal_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sal_pkg::*;

  localparam int RANDOM_ITEMS = 1926;
  localparam int CALM_TAIL    = 200;   // last requests run with no idling on either side
  localparam int HOLD_AFTER   = 600;   // accepted requests before the long m_axis hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DIRECTED_N   = 24;

  localparam logic [2:0] ST_EXCLUSIVE = 3'd3;
  localparam logic [2:0] ST_RSVD5     = 3'd5;
  localparam logic [2:0] ST_RSVD7     = 3'd7;
  localparam logic [2:0] OP_RSVD5     = 3'd5;
  localparam logic [2:0] OP_RSVD6     = 3'd6;
  localparam logic [2:0] OP_RSVD7     = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  set_idx;
    logic [31:0] tag;
    logic [2:0]  state;
  } request_t;

  typedef struct {
    logic        hit;
    logic [2:0]  line_state;
    logic [31:0] victim_tag;
    logic        writeback;
  } report_t;

  typedef struct {
    request_t req;
    bit       fixed;   // want is read straight off the spec
    report_t  want;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // mirror of the tag store
  logic [31:0] way_tag   [SETS][WAYS];
  logic [2:0]  way_state [SETS][WAYS];
  int unsigned way_age   [SETS][WAYS];

  report_t set_reports[$];
  int      mismatches = 0;
  int      accepted = 0;
  bit      quiet = 1'b0;
  int      tx_rate = 0;
  int      rx_rate = 0;
  int      rx_gap = 0;
  logic    rx_hold = 1'b0;

  directed_row_t directed [DIRECTED_N];

  set_assoc_lru_tag_store uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void make_recent(int s, int w);
    int unsigned a;
    a = way_age[s][w];
    for (int k = 0; k < WAYS; k++) begin
      if (way_age[s][k] < a) way_age[s][k] = way_age[s][k] + 1;
    end
    way_age[s][w] = 0;
  endfunction

  // Report reflects the set before the request; then the request is applied.
  function automatic report_t access_set(request_t r);
    report_t    rep;
    int         s;
    int         hw;
    int         lru;
    bit         hit;
    logic [2:0] ns;
    s   = int'(r.set_idx) % SETS;
    ns  = (r.state > ST_SHARED) ? ST_INVALID : r.state;
    hit = 1'b0;
    hw  = 0;
    lru = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && way_tag[s][w] == r.tag) begin
        hit = 1'b1;
        hw  = w;
      end
      if (way_age[s][w] > way_age[s][lru]) lru = w;
    end
    rep.hit        = hit;
    rep.line_state = hit ? way_state[s][hw] : ST_INVALID;
    rep.victim_tag = way_tag[s][lru];
    rep.writeback  = (way_state[s][lru] == ST_MODIFIED) || (way_state[s][lru] == ST_OWNED);
    case (r.op)
      OP_SET_STATE: if (hit) way_state[s][hw] = ns;
      OP_TOUCH: if (hit) make_recent(s, hw);
      OP_INSERT: begin
        if (!hit) begin
          way_tag[s][lru] = r.tag;
          hw = lru;
        end
        way_state[s][hw] = ns;
        make_recent(s, hw);
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Biased toward hot sets and resident tags so hits, evictions and
  // same-set back-to-back requests are frequent.
  function automatic request_t random_request();
    request_t    r;
    logic [31:0] hot_tags [8];
    int          s;
    hot_tags = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'hA5A5_5A5A, 32'h5A5A_A5A5};
    r.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0 && r.op < OP_RSVD5) r.op = OP_INSERT;
    case ($urandom_range(0, 3))
      0, 1: r.set_idx = 6'($urandom_range(0, 3));
      2: r.set_idx = 6'($urandom_range(0, 63));
      default: r.set_idx = 6'($urandom_range(60, 63));
    endcase
    s = int'(r.set_idx) % SETS;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: r.tag = way_tag[s][$urandom_range(0, WAYS - 1)];
      12, 13, 14, 15, 16: r.tag = hot_tags[$urandom_range(0, 7)];
      default: r.tag = $urandom;
    endcase
    r.state = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    return r;
  endfunction

  task automatic offer(input request_t r, input bit fixed, input report_t want);
    int      gap;
    report_t rep;
    if (!quiet && $urandom_range(0, 99) < tx_rate) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({r.state, r.tag, r.set_idx, r.op});
    do @(posedge clk); while (!s_axis_tready);
    rep = access_set(r);
    set_reports.push_back(fixed ? want : rep);
    accepted++;
  endtask

  // result side: random stalls, plus the long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else if (!quiet && $urandom_range(0, 99) < rx_rate) begin
      m_axis_tready <= 1'b0;
      rx_gap = $urandom_range(0, 17);
    end else begin
      m_axis_tready <= !rx_hold;
    end
  end

  initial begin
    wait (accepted >= HOLD_AFTER);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit        = m_axis_tdata[0];
      got.line_state = m_axis_tdata[3:1];
      got.victim_tag = m_axis_tdata[35:4];
      got.writeback  = m_axis_tdata[36];
      if (set_reports.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: hit=%0d state=%0d victim=%h wb=%0d",
                   got.hit, got.line_state, got.victim_tag, got.writeback);
        mismatches++;
      end else begin
        want = set_reports.pop_front();
        if (got.hit !== want.hit || got.line_state !== want.line_state ||
            got.victim_tag !== want.victim_tag || got.writeback !== want.writeback) begin
          if (mismatches < 10)
            $display("mismatch: exp hit=%0d state=%0d victim=%h wb=%0d, got hit=%0d state=%0d victim=%h wb=%0d",
                     want.hit, want.line_state, want.victim_tag, want.writeback,
                     got.hit, got.line_state, got.victim_tag, got.writeback);
          mismatches++;
        end
      end
    end
  end

  initial begin
    report_t  none;
    request_t r;
    none = '{1'b0, ST_INVALID, 32'h0, 1'b0};
    for (int s = 0; s < SETS; s++) begin
      for (int j = 0; j < WAYS; j++) begin
        way_tag[s][j]   = 32'(j);
        way_state[s][j] = ST_INVALID;
        way_age[s][j]   = WAYS - 1 - j;
      end
    end

    directed = '{
      // reset contents: way j holds tag j, invalid, way 0 oldest
      '{'{OP_LOOKUP,    6'd0,  32'h0,         ST_INVALID},  1'b1,
        '{1'b1, ST_INVALID, 32'h0, 1'b0}},
      '{'{OP_LOOKUP,    6'd63, 32'hFFFF_FFFF, ST_INVALID},  1'b1,
        '{1'b0, ST_INVALID, 32'h0, 1'b0}},
      '{'{OP_CHECK,     6'd63, 32'h3,         ST_INVALID},  1'b1,
        '{1'b1, ST_INVALID, 32'h0, 1'b0}},
      '{'{OP_INSERT,    6'd0,  32'hFFFF_FFFF, ST_MODIFIED}, 1'b1,
        '{1'b0, ST_INVALID, 32'h0, 1'b0}},
      '{'{OP_LOOKUP,    6'd0,  32'hFFFF_FFFF, ST_INVALID},  1'b0, none},
      '{'{OP_SET_STATE, 6'd0,  32'h1,         ST_OWNED},    1'b0, none},
      '{'{OP_CHECK,     6'd0,  32'h1,         ST_INVALID},  1'b0, none},
      '{'{OP_TOUCH,     6'd0,  32'h2,         ST_INVALID},  1'b0, none},
      // touch and set-state misses leave the set alone
      '{'{OP_TOUCH,     6'd0,  32'd77,        ST_INVALID},  1'b0, none},
      '{'{OP_SET_STATE, 6'd0,  32'd99,        ST_MODIFIED}, 1'b0, none},
      // insert of a resident tag: no eviction
      '{'{OP_INSERT,    6'd0,  32'hFFFF_FFFF, ST_SHARED},   1'b0, none},
      '{'{OP_INSERT,    6'd0,  32'h1234_5678, ST_EXCLUSIVE}, 1'b0, none},
      // out-of-range state codes store as invalid
      '{'{OP_INSERT,    6'd0,  32'h0,         ST_RSVD7},    1'b0, none},
      '{'{OP_SET_STATE, 6'd0,  32'h1234_5678, ST_RSVD5},    1'b0, none},
      '{'{OP_RSVD5,     6'd1,  32'h0,         ST_MODIFIED}, 1'b0, none},
      '{'{OP_RSVD6,     6'd62, 32'hFFFF_FFFF, ST_RSVD7},    1'b0, none},
      '{'{OP_RSVD7,     6'd63, 32'h8000_0000, ST_SHARED},   1'b0, none},
      // fill set 63 and push a dirty line out
      '{'{OP_INSERT,    6'd63, 32'h8000_0000, ST_OWNED},    1'b0, none},
      '{'{OP_INSERT,    6'd63, 32'h7FFF_FFFF, ST_MODIFIED}, 1'b0, none},
      '{'{OP_INSERT,    6'd63, 32'hAAAA_AAAA, ST_SHARED},   1'b0, none},
      '{'{OP_INSERT,    6'd63, 32'h5555_5555, ST_EXCLUSIVE}, 1'b0, none},
      '{'{OP_CHECK,     6'd63, 32'h0,         ST_INVALID},  1'b0, none},
      '{'{OP_INSERT,    6'd63, 32'hDEAD_BEEF, ST_MODIFIED}, 1'b0, none},
      '{'{OP_LOOKUP,    6'd63, 32'h5555_5555, ST_INVALID},  1'b0, none}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_rate = 30;
    rx_rate = 30;
    foreach (directed[i]) offer(directed[i].req, directed[i].fixed, directed[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_rate = 0;
          1: tx_rate = 10;
          default: tx_rate = 40;
        endcase
        case ($urandom_range(0, 2))
          0: rx_rate = 0;
          1: rx_rate = 10;
          default: rx_rate = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_TAIL) quiet = 1'b1;
      r = random_request();
      offer(r, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (set_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && set_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sal_pkg.sv
hdl/sal_ram.sv
hdl/sal_row_update.sv
hdl/set_assoc_lru_tag_store.sv
hdl/sal_checker.sv
tb/sv/tb_top.sv
